// ===== hdl/smd_pkg.sv =====
// SHA-1 message digest: shared types, constants and controller/datapath command codes.
// No dependencies.
package smd_pkg;

    typedef logic [31:0] t_word;

    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned NUM_WORDS  = 5;
    localparam int unsigned BLK_WORDS  = 16;

    localparam t_word H_INIT [NUM_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam t_word K_ROUND [4] = '{
        32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
    };

    // byte source for the block buffer
    localparam logic [1:0] BSEL_DATA  = 2'd0;
    localparam logic [1:0] BSEL_PAD80 = 2'd1;
    localparam logic [1:0] BSEL_ZERO  = 2'd2;
    localparam logic [1:0] BSEL_LEN   = 2'd3;

    // round function group
    localparam logic [1:0] F_CH   = 2'd0;
    localparam logic [1:0] F_PAR1 = 2'd1;
    localparam logic [1:0] F_MAJ  = 2'd2;
    localparam logic [1:0] F_PAR2 = 2'd3;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic       put_byte;
        logic [1:0] byte_sel;
        logic       count_len;
        logic       round;
        logic [1:0] round_grp;
        logic       finish;
        logic       clear;
        logic [2:0] word_idx;
    } t_dp_cmd;

endpackage

// ===== hdl/smd_datapath.sv =====
// SHA-1 datapath: byte-shift block buffer / message schedule window, round registers,
// chaining words, bit length and byte position. Depends on smd_pkg.
module smd_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  smd_pkg::t_dp_cmd i_cmd,
    input  logic [7:0]       i_data_byte,
    output logic [5:0]       o_pos,
    output smd_pkg::t_word   o_digest_word
);

    smd_pkg::t_word r_w [smd_pkg::BLK_WORDS];
    smd_pkg::t_word r_h [smd_pkg::NUM_WORDS];
    smd_pkg::t_word r_a, r_b, r_c, r_d, r_e;
    logic [63:0]    r_len;
    logic [5:0]     r_pos;

    logic [7:0]     w_byte;
    smd_pkg::t_word w_sched;
    smd_pkg::t_word w_f;
    smd_pkg::t_word w_t;

    always_comb begin
        unique case (i_cmd.byte_sel)
            smd_pkg::BSEL_DATA:  w_byte = i_data_byte;
            smd_pkg::BSEL_PAD80: w_byte = smd_pkg::PAD_BYTE;
            smd_pkg::BSEL_ZERO:  w_byte = 8'h00;
            default:             w_byte = r_len[{3'd7 - r_pos[2:0], 3'b000} +: 8];
        endcase
    end

    always_comb begin
        smd_pkg::t_word v;
        v = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_sched = {v[30:0], v[31]};
    end

    always_comb begin
        unique case (i_cmd.round_grp)
            smd_pkg::F_CH:                   w_f = (r_b & r_c) | (~r_b & r_d);
            smd_pkg::F_MAJ:                  w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            default:                         w_f = r_b ^ r_c ^ r_d;
        endcase
    end

    assign w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + smd_pkg::K_ROUND[i_cmd.round_grp]
               + r_w[0];

    // block buffer: byte shift on load, word shift per round
    always_ff @(posedge i_clk) begin
        if (i_cmd.put_byte) begin
            for (int i = 0; i < smd_pkg::BLK_WORDS - 1; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[smd_pkg::BLK_WORDS-1] <= {r_w[smd_pkg::BLK_WORDS-1][23:0], w_byte};
        end else if (i_cmd.round) begin
            for (int i = 0; i < smd_pkg::BLK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[smd_pkg::BLK_WORDS-1] <= w_sched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put_byte && r_pos == 6'd63) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round) begin
            r_a <= w_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < smd_pkg::NUM_WORDS; i++) begin
                r_h[i] <= smd_pkg::H_INIT[i];
            end
            r_len <= '0;
            r_pos <= '0;
        end else begin
            if (i_cmd.finish) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
            if (i_cmd.count_len) begin
                r_len <= r_len + 64'd8;
            end
            if (i_cmd.put_byte) begin
                r_pos <= r_pos + 6'd1;
            end
        end
    end

    always_comb begin
        case (i_cmd.word_idx)
            3'd0:    o_digest_word = r_h[0];
            3'd1:    o_digest_word = r_h[1];
            3'd2:    o_digest_word = r_h[2];
            3'd3:    o_digest_word = r_h[3];
            default: o_digest_word = r_h[4];
        endcase
    end

    assign o_pos = r_pos;

endmodule

// ===== hdl/smd_ctrl.sv =====
// SHA-1 controller: input acceptance, padding sequence, round count, digest output.
// Depends on smd_pkg; drives smd_datapath through t_dp_cmd.
module smd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_byte_valid,
    input  logic             i_end_of_message,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    input  logic [5:0]       i_pos,
    output logic [2:0]       o_word_index,
    output logic             o_last_word,
    output smd_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [6:0] r_rnd, n_rnd;
    logic [2:0] r_widx, n_widx;
    logic       r_eom, n_eom;
    logic       r_first, n_first;
    logic       r_lenph, n_lenph;
    logic       r_last, n_last;
    logic       w_lenph_now;

    assign w_lenph_now = r_lenph | (!r_first && i_pos == 6'd56);

    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        n_widx  = r_widx;
        n_eom   = r_eom;
        n_first = r_first;
        n_lenph = r_lenph;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.byte_sel = smd_pkg::BSEL_DATA;
        o_cmd.word_idx = r_widx;
        o_ready = 1'b0;
        o_valid = 1'b0;

        if (r_rnd < 7'd20) begin
            o_cmd.round_grp = smd_pkg::F_CH;
        end else if (r_rnd < 7'd40) begin
            o_cmd.round_grp = smd_pkg::F_PAR1;
        end else if (r_rnd < 7'd60) begin
            o_cmd.round_grp = smd_pkg::F_MAJ;
        end else begin
            o_cmd.round_grp = smd_pkg::F_PAR2;
        end

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_eom   = i_end_of_message;
                    n_first = 1'b1;
                    n_lenph = 1'b0;
                    n_last  = 1'b0;
                    if (i_byte_valid) begin
                        o_cmd.put_byte  = 1'b1;
                        o_cmd.count_len = 1'b1;
                        if (i_pos == 6'd63) begin
                            n_rnd   = '0;
                            n_state = S_COMP;
                        end else if (i_end_of_message) begin
                            n_state = S_PAD;
                        end
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.put_byte = 1'b1;
                if (r_first) begin
                    o_cmd.byte_sel = smd_pkg::BSEL_PAD80;
                end else if (w_lenph_now) begin
                    o_cmd.byte_sel = smd_pkg::BSEL_LEN;
                end else begin
                    o_cmd.byte_sel = smd_pkg::BSEL_ZERO;
                end
                n_first = 1'b0;
                n_lenph = w_lenph_now;
                if (i_pos == 6'd63) begin
                    n_last  = w_lenph_now;
                    n_rnd   = '0;
                    n_state = S_COMP;
                end
            end
            S_COMP: begin
                o_cmd.round = 1'b1;
                n_rnd = r_rnd + 7'd1;
                if (r_rnd == 7'(smd_pkg::NUM_ROUNDS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                if (r_last) begin
                    n_widx  = '0;
                    n_state = S_OUT;
                end else if (r_eom) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (r_widx == 3'(smd_pkg::NUM_WORDS - 1)) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_widx = r_widx + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd   <= '0;
            r_widx  <= '0;
            r_eom   <= 1'b0;
            r_first <= 1'b0;
            r_lenph <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            r_widx  <= n_widx;
            r_eom   <= n_eom;
            r_first <= n_first;
            r_lenph <= n_lenph;
            r_last  <= n_last;
        end
    end

    assign o_word_index = r_widx;
    assign o_last_word  = (r_widx == 3'(smd_pkg::NUM_WORDS - 1));

`ifndef SYNTHESIS
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP) |-> (r_rnd < 7'd80))
        else $error("round counter out of range");

    a_comp_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMP && $past(r_state) != S_COMP) |-> ($past(i_pos) == 6'd63))
        else $error("compression started without a full block");

    a_out_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && $past(r_state) != S_OUT) |-> ($past(r_state) == S_FIN))
        else $error("digest output without a final compression");

    a_widx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_widx <= 3'd4))
        else $error("word index out of range");
`endif

endmodule

// ===== hdl/sha1_message_digest.sv =====
// SHA-1 message digest, one message byte per input transaction, five digest words out.
// Top level; instantiates smd_ctrl and smd_datapath, uses smd_pkg.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  input   | i_valid / o_ready  | i_data_byte, i_byte_valid, i_end_of_message
//  output  | o_valid / i_ready  | o_digest_word, o_word_index, o_last_word
//
// Each message byte is one input transaction; the 64th byte of a block starts its
// compression (80 rounds of the single round unit, then the chaining add).
// End of message: 9 to 72 padding bytes are appended, each padded block is compressed,
// then five output transactions follow. Input is not taken during compression,
// padding or output. Synchronous active-low reset restores the initial chaining
// words and zero length. Output stalls hold the state machine in place.
module sha1_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    smd_pkg::t_dp_cmd w_cmd;
    logic [5:0]       w_pos;

    smd_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_byte_valid     (i_byte_valid),
        .i_end_of_message (i_end_of_message),
        .o_ready          (o_ready),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .i_pos            (w_pos),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word),
        .o_cmd            (w_cmd)
    );

    smd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_data_byte   (i_data_byte),
        .o_pos         (w_pos),
        .o_digest_word (o_digest_word)
    );

endmodule

// ===== tb/tb_sha1_message_digest.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sha1_message_digest: byte transactions in, digest words out.
// Depends on smd_pkg and the sha1_message_digest RTL; carries its own SHA-1 predictor.
module tb_sha1_message_digest;

    localparam int unsigned WAIT_MAX     = 19;
    localparam int unsigned WDOG_LIMIT   = 4000;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned RAND_ITEMS   = 400;

    typedef struct packed {
        smd_pkg::t_word word;
        logic [2:0]     idx;
        logic           last;
    } t_digest_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_byte_valid;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    smd_pkg::t_word chain_h [smd_pkg::NUM_WORDS];
    smd_pkg::t_word block_buf [smd_pkg::BLK_WORDS];
    logic [63:0]    msg_bits;
    t_digest_out    digest_q [$];

    int unsigned err_count;
    int unsigned words_checked;
    int unsigned items_sent;
    int unsigned msg_count;
    int unsigned longest_msg;
    int unsigned idle_cycles;
    bit          tx_steady;
    bit          rx_steady;

    sha1_message_digest u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_byte_valid     (i_byte_valid),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic smd_pkg::t_word rotl(smd_pkg::t_word v, int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic clear_digest_state();
        for (int i = 0; i < smd_pkg::NUM_WORDS; i++) chain_h[i] = smd_pkg::H_INIT[i];
        for (int i = 0; i < smd_pkg::BLK_WORDS; i++) block_buf[i] = '0;
        msg_bits = '0;
    endtask

    task automatic compress_block();
        smd_pkg::t_word w [16];
        smd_pkg::t_word a, b, c, d, e, f, k, x, t;
        for (int i = 0; i < 16; i++) w[i] = block_buf[i];
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < smd_pkg::NUM_ROUNDS; r++) begin
            if (r < 16) begin
                x = w[r];
            end else begin
                x = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
                w[r % 16] = x;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = smd_pkg::K_ROUND[0];
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = smd_pkg::K_ROUND[1];
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = smd_pkg::K_ROUND[2];
            end else begin
                f = b ^ c ^ d;
                k = smd_pkg::K_ROUND[3];
            end
            t = rotl(a, 5) + f + e + k + x;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    task automatic place_byte(int unsigned pos, logic [7:0] val);
        int unsigned idx;
        int unsigned lane;
        idx  = pos / 4;
        lane = (3 - pos % 4) * 8;
        if (pos % 4 == 0) block_buf[idx] = smd_pkg::t_word'(val) << lane;
        else              block_buf[idx] |= smd_pkg::t_word'(val) << lane;
        if (pos == 63) compress_block();
    endtask

    task automatic absorb_byte(logic [7:0] val);
        place_byte(int'(msg_bits[8:3]), val);
        msg_bits += 64'd8;
    endtask

    task automatic finish_message();
        logic [63:0] len;
        int unsigned pos;
        len = msg_bits;
        pos = int'(len[8:3]);
        place_byte(pos, smd_pkg::PAD_BYTE);
        pos = (pos + 1) % 64;
        while (pos != 56) begin
            place_byte(pos, 8'h00);
            pos = (pos + 1) % 64;
        end
        for (int i = 0; i < 8; i++) place_byte(56 + i, len[63 - 8 * i -: 8]);
        for (int i = 0; i < smd_pkg::NUM_WORDS; i++)
            digest_q.push_back('{chain_h[i], 3'(i), (i == smd_pkg::NUM_WORDS - 1)});
        clear_digest_state();
    endtask

    // ---------------- input driver ----------------
    task automatic send_item(input logic [7:0] data, input logic has_byte, input logic eom);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, WAIT_MAX);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_data_byte      <= data;
        i_byte_valid     <= has_byte;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (!o_ready);
        if (has_byte) absorb_byte(data);
        if (eom) begin
            finish_message();
            msg_count++;
        end
        if (has_byte || eom) items_sent++;
    endtask

    // random bytes with optional no-op transactions mixed in, ending on the last byte or with a separate end marker
    task automatic send_message(int unsigned len, bit end_on_byte, int unsigned noise_pct);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte || len == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
        if (len > longest_msg) longest_msg = len;
    endtask

    // ---------------- tests ----------------
    task automatic test_empty_message();
        send_item(8'hff, 1'b0, 1'b1);
    endtask

    task automatic test_abc_end_on_byte();
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        if (longest_msg < 3) longest_msg = 3;
    endtask

    task automatic test_ignored_items();
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h5a, 1'b1, 1'b0);
        send_item(8'ha5, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);
    endtask

    task automatic test_random_messages();
        int unsigned len;
        while (items_sent < RAND_ITEMS) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9)) inside
                [0:4]:   len = $urandom_range(0, 20);
                [5:7]:   len = $urandom_range(52, 66);
                8:       len = $urandom_range(0, 130);
                default: len = $urandom_range(116, 130);
            endcase
            send_message(len, $urandom_range(0, 1), $urandom_range(0, 1) ? 10 : 0);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ---------------- output side ----------------
    initial begin
        int unsigned stall;
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, WAIT_MAX);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        t_digest_out exp_w;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (o_valid && i_ready) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest transaction word=%h idx=%0d last=%0b",
                             $time, o_digest_word, o_word_index, o_last_word);
                    err_count++;
                end else begin
                    exp_w = digest_q.pop_front();
                    words_checked++;
                    if (o_digest_word !== exp_w.word) begin
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, exp_w.word, o_digest_word);
                        err_count++;
                    end
                    if (o_word_index !== exp_w.idx) begin
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, exp_w.idx, o_word_index);
                        err_count++;
                    end
                    if (o_last_word !== exp_w.last) begin
                        $display("%0t: last_word expected %0b actual %0b",
                                 $time, exp_w.last, o_last_word);
                        err_count++;
                    end
                end
            end
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("%0t: timeout, %0d digest words still pending", $time, digest_q.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        err_count     = 0;
        words_checked = 0;
        items_sent    = 0;
        msg_count     = 0;
        longest_msg   = 0;
        idle_cycles   = 0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        clear_digest_state();
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_data_byte      <= 8'h00;
        i_byte_valid     <= 1'b0;
        i_end_of_message <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_message();
        test_abc_end_on_byte();
        test_ignored_items();
        test_random_messages();

        i_valid <= 1'b0;
        wait (digest_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d messages (longest %0d bytes) from %0d byte/end transactions,",
                 msg_count, longest_msg, items_sent);
        $display("with %0d digest words checked and %0d mismatches.", words_checked, err_count);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
